[rtl/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clk, rst, prop)
`else
`define ASSERT_CLK(label, clock, reset, prop)
`define ASSERT_STD(label, prop)
`endif
`endif

[rtl/dmm_pkg.sv]
package dmm_pkg;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_INNER  = 2'd2;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int ACC_W  = 40;
  localparam int PROD_W = 32;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef struct packed {
    logic               wa;
    logic               wb;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] data;
  } dmm_wr_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] row;
    logic [3:0] col;
  } dmm_req_t;

endpackage

[rtl/dmm_cell.sv]
module dmm_cell
  import dmm_pkg::*;
#(
  parameter int DIM = 16,
  parameter int K   = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dmm_wr_t                 wr,
  input  dmm_req_t                req_in,
  input  logic signed [ACC_W-1:0] acc_in,
  input  logic [4:0]              inner_used,
  output dmm_req_t                req_out,
  output logic signed [ACC_W-1:0] acc_out,
  output logic                    acc_valid
);

  localparam int IW = $clog2(DIM);

  // column K of A and row K of B live here
  logic signed [15:0] a_mem [DIM];
  logic signed [15:0] b_mem [DIM];

  logic [31:0] wr_row_ext, wr_col_ext, rq_row_ext, rq_col_ext;
  logic        a_hit, b_hit, use_k;
  logic signed [15:0] rd_a, rd_b;
  logic signed [PROD_W-1:0] prod;
  logic rd_v, prod_v;

  always_comb begin
    wr_row_ext = 32'(wr.row);
    wr_col_ext = 32'(wr.col);
    rq_row_ext = 32'(req_in.row);
    rq_col_ext = 32'(req_in.col);
    a_hit = wr.wa && (wr_col_ext == 32'(K)) && (wr_row_ext < 32'(DIM));
    b_hit = wr.wb && (wr_row_ext == 32'(K)) && (wr_col_ext < 32'(DIM));
    use_k = 32'(K) < 32'(inner_used);
  end

  always_ff @(posedge clk) begin
    if (a_hit) a_mem[wr_row_ext[IW-1:0]] <= wr.data;
    if (b_hit) b_mem[wr_col_ext[IW-1:0]] <= wr.data;
    rd_a <= a_mem[rq_row_ext[IW-1:0]];
    rd_b <= b_mem[rq_col_ext[IW-1:0]];
    req_out.row <= req_in.row;
    req_out.col <= req_in.col;
    prod <= rd_a * rd_b;
    // partial sum from the left neighbor is added to this cell's registered product
    acc_out <= use_k ? acc_in + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} : acc_in;
    if (rst) begin
      req_out.valid <= 1'b0;
      rd_v          <= 1'b0;
      prod_v        <= 1'b0;
      acc_valid     <= 1'b0;
    end else begin
      req_out.valid <= req_in.valid;
      rd_v          <= req_in.valid;
      prod_v        <= rd_v;
      acc_valid     <= prod_v;
    end
  end

endmodule

[rtl/dense_matrix_multiply.sv]
// dense matrix multiply: C(i,j) = sum over k < inner_used of A(i,k) * B(k,j)
// command channel: an item transfers at a clock edge with start high and busy low.
//   opcode write A / write B stores one signed Q8.8 element; busy stays low,
//   so writes may follow every cycle while no read holds busy high.
//   opcode read starts one dot product; busy is high until the result is out.
// the product runs down a chain of DIM cells, cell k holding column k of A and
//   row k of B; the request steps one cell per cycle and each cell adds its
//   product to the partial sum passed from its left neighbor.
// a read passes from transfer through the request register, the cell chain and
//   the result registers; the next item may transfer in the cycle done is high.
// result: done is high for one cycle with product_value (Q24.16), out_row,
//   out_col and range_error; the receiver cannot stall; values hold until the next result.
// a read outside the configured rows or columns returns zero with range_error.
// config channel: cfg_valid/cfg_ready write cfg_data to register cfg_index;
//   cfg_ready is always high; write only while idle.
// reset: sizes return to 16, busy and done clear; store contents are undefined
//   until written.
`include "assert_macros.svh"
module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int DIM = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [3:0]              row_index,
  input  logic [3:0]              col_index,
  input  logic signed [15:0]      element_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [4:0]              cfg_data,
  output logic                    done,
  output logic signed [ACC_W-1:0] product_value,
  output logic [3:0]              out_row,
  output logic [3:0]              out_col,
  output logic                    range_error
);

  state_t state, state_next;
  logic [4:0] rows_used, cols_used, inner_used;
  logic       accept, rd_start, err_now, err;
  logic [31:0] nr, nc;
  dmm_wr_t    wr;
  dmm_req_t   req [DIM+1];
  logic signed [ACC_W-1:0] acc [DIM+1];
  logic       acc_v [DIM];

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rd_start  = accept && (opcode == OP_READ);

  always_comb begin
    nr = (32'(rows_used) > 32'(DIM)) ? 32'(DIM) : 32'(rows_used);
    nc = (32'(cols_used) > 32'(DIM)) ? 32'(DIM) : 32'(cols_used);
    err_now = (32'(row_index) >= nr) || (32'(col_index) >= nc);
    wr.wa   = accept && (opcode == OP_WRITE_A);
    wr.wb   = accept && (opcode == OP_WRITE_B);
    wr.row  = row_index;
    wr.col  = col_index;
    wr.data = element_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= 5'd16;
      cols_used  <= 5'd16;
      inner_used <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:  rows_used  <= cfg_data;
        CFG_COLS:  cols_used  <= cfg_data;
        CFG_INNER: inner_used <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (rd_start) state_next = ST_RUN;
      ST_RUN:  if (acc_v[DIM-1]) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == ST_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= acc_v[DIM-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req[0].valid <= 1'b0;
    end else begin
      req[0].valid <= rd_start;
    end
    if (rd_start) begin
      req[0].row <= row_index;
      req[0].col <= col_index;
      err        <= err_now;
    end
    if (acc_v[DIM-1]) begin
      product_value <= err ? '0 : acc[DIM];
      out_row       <= req[0].row;
      out_col       <= req[0].col;
      range_error   <= err;
    end
  end

  assign acc[0] = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    dmm_cell #(.DIM(DIM), .K(k)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr         (wr),
      .req_in     (req[k]),
      .acc_in     (acc[k]),
      .inner_used (inner_used),
      .req_out    (req[k+1]),
      .acc_out    (acc[k+1]),
      .acc_valid  (acc_v[k])
    );
  end

  `ASSERT_STD(a_done_after_run, done |-> $past(state == ST_RUN))
  `ASSERT_STD(a_read_sets_busy, rd_start |=> busy)
  `ASSERT_STD(a_err_gives_zero, (done && range_error) |-> (product_value == '0))
  `ASSERT_STD(a_idle_chain_quiet, (state == ST_IDLE) |-> !acc_v[DIM-1])

endmodule
